/* src/free_extent_allocator_unit_macros.svh */
// assertion macros for the free extent allocator
`ifndef FREE_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_EXTENT_ALLOCATOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FEA_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("free extent allocator check failed");
// next-cycle implication
`define FEA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("free extent allocator check failed");
`else
`define FEA_ASSERT_IMPLY(label, clk, rst, cond, prop)
`define FEA_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

/* src/fea_pkg.sv */
// shared types and constants of the free extent allocator
`default_nettype none
package fea_pkg;
   localparam int DEF_EXTENT_SLOTS = 16;
   localparam int DEF_OFFSET_BITS  = 16;
   localparam int DEF_FREE_HEADER  = 24;
   localparam int DEF_USED_HEADER  = 8;
   localparam int HEAP_SLACK_HEADERS = 5;

   localparam int FIELD_W  = 16;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;
   localparam int FIT_W    = 2;

   localparam logic [FIELD_W-1:0] HEAP_BYTES_RESET = 16'd4096;

   localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [FIT_W-1:0] FIT_NEXT  = 2'd2;
   localparam logic [FIT_W-1:0] FIT_WORST = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL = 2'd2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic CSR_FIT_MODE   = 1'b0;
   localparam logic CSR_HEAP_BYTES = 1'b1;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic init;
      logic load;
      logic scan;
      logic decide;
      logic shift;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic init_req;
      logic scan_done;
      logic shift_done;
      logic out_busy;
   } dp_status_type;
endpackage
`default_nettype wire

/* src/fea_ctrl.sv */
// sequencing state machine of the free extent allocator
`default_nettype none
module fea_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  fea_pkg::dp_status_type status,
   output fea_pkg::ctrl_cmd_type  cmd
);
   import fea_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.init_req) begin
               state_in = ST_INIT;
            end else if (req_tvalid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (status.shift_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.init = 1'b1;
         end
         ST_IDLE: begin
            req_tready = !status.init_req;
            cmd.load   = !status.init_req && req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end
endmodule
`default_nettype wire

/* src/fea_datapath.sv */
// extent table memory, scan, split, merge and shift datapath
`default_nettype none
module fea_datapath #(
   parameter int EXTENT_SLOTS = fea_pkg::DEF_EXTENT_SLOTS,
   parameter int OFFSET_BITS  = fea_pkg::DEF_OFFSET_BITS,
   parameter int FREE_HEADER  = fea_pkg::DEF_FREE_HEADER,
   parameter int USED_HEADER  = fea_pkg::DEF_USED_HEADER
) (
   input  wire                               clock,
   input  wire                               reset,
   input  fea_pkg::ctrl_cmd_type             cmd,
   input  wire                               csr_we,
   input  wire                               csr_index,
   input  wire  [fea_pkg::FIELD_W-1:0]       csr_wdata,
   input  wire                               in_kind,
   input  wire  [fea_pkg::FIELD_W-1:0]       in_request_bytes,
   input  wire  [fea_pkg::FIELD_W-1:0]       in_block_offset,
   input  wire  [fea_pkg::FIELD_W-1:0]       in_block_bytes,
   input  wire                               rsp_tready,
   output fea_pkg::dp_status_type            status,
   output logic                              out_valid,
   output logic [fea_pkg::STATUS_W-1:0]      out_status,
   output logic [fea_pkg::FIELD_W-1:0]       out_offset,
   output logic [fea_pkg::FIELD_W-1:0]       out_granted,
   output logic [fea_pkg::COUNT_W-1:0]       out_count
);
   import fea_pkg::*;

   localparam int IW = $clog2(EXTENT_SLOTS);
   localparam int TW = $clog2(EXTENT_SLOTS + 1);
   localparam int OW = OFFSET_BITS;
   localparam int EW = 2 * OW;
   localparam int CW = ((OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W) + 2;
   localparam logic [CW-1:0] OFF_MASK = CW'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam logic [CW-1:0] FH_C     = CW'(FREE_HEADER);
   localparam logic [CW-1:0] UH_C     = CW'(USED_HEADER);
   localparam logic [CW-1:0] SLACK_C  = CW'(HEAP_SLACK_HEADERS * FREE_HEADER);
   localparam logic [TW-1:0] SLOTS_C  = TW'(EXTENT_SLOTS);

   // entry layout: length above start
   logic [EW-1:0] mem [EXTENT_SLOTS];

   // control state
   logic [FIT_W-1:0]   fit_ff;
   logic [FIELD_W-1:0] heap_ff;
   logic               init_req_ff;
   logic [TW-1:0]      total_ff;
   logic [TW-1:0]      rover_ff;
   logic               rvalid_ff;
   logic               rd_vld_ff;
   logic [TW-1:0]      k_ff;
   logic               pick_found_ff;
   logic               pfound_ff;
   logic               shift_active_ff;
   logic               out_vld_ff;

   // payload state
   logic [EW-1:0]      rd_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               kind_ff;
   logic [FIELD_W-1:0] req_ff;
   logic [CW-1:0]      need_ff, ns_ff, nl_ff;
   logic               boff_low_ff;
   logic [TW-1:0]      m_ff, scan_len_ff;
   logic [IW-1:0]      pick_idx_ff;
   logic [CW-1:0]      pick_s_ff, pick_l_ff;
   logic [TW-1:0]      p_ff;
   logic [CW-1:0]      prev_s_ff, prev_l_ff, next_s_ff, next_l_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [FIELD_W-1:0] res_off_ff, res_gr_ff;
   logic [TW-1:0]      new_total_ff, new_rover_ff;
   logic               new_rvalid_ff;
   logic               fin_we_ff;
   logic [IW-1:0]      fin_addr_ff;
   logic [EW-1:0]      fin_data_ff;
   logic               shift_up_ff;
   logic [TW-1:0]      sc_ff, sc_end_ff;
   logic [STATUS_W-1:0] out_status_ff;
   logic [FIELD_W-1:0] out_off_ff, out_gr_ff;
   logic [COUNT_W-1:0] out_count_ff;

   // decide values
   logic [STATUS_W-1:0] res_status_in;
   logic [FIELD_W-1:0] res_off_in, res_gr_in;
   logic [TW-1:0]      new_total_in, new_rover_in;
   logic               new_rvalid_in;
   logic               fin_we_in;
   logic [IW-1:0]      fin_addr_in;
   logic [EW-1:0]      fin_data_in;
   logic               shift_active_in, shift_up_in;
   logic [TW-1:0]      sc_in, sc_end_in;

   logic [CW-1:0]      span_c, span_sum;
   logic [CW-1:0]      need_c, nl_c, nl_raw;
   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;
   logic [CW-1:0]      e_s, e_l;
   logic               take;
   logic [TW:0]        order_sum;
   logic               scan_issue, shift_issue;

   // heap span: requested size plus slack, clamped to what an offset holds and to at least one free header
   always_comb begin
      span_sum = CW'(heap_ff) + SLACK_C;
      span_c   = span_sum;
      if (span_sum > OFF_MASK) begin
         span_c = OFF_MASK;
      end
      if (span_c < FH_C) begin
         span_c = FH_C;
      end
   end

   always_comb begin
      need_c = CW'(in_request_bytes) + UH_C;
      if (need_c < FH_C) begin
         need_c = FH_C;
      end
      nl_raw = CW'(in_block_bytes) + UH_C;
      if (nl_raw < FH_C) begin
         nl_raw = FH_C;
      end
      nl_c = nl_raw - FH_C;
   end

   // read port
   assign scan_issue  = cmd.scan && (k_ff != scan_len_ff);
   assign shift_issue = cmd.shift && shift_active_ff && (sc_ff != sc_end_ff);
   assign rd_en       = scan_issue || shift_issue;

   always_comb begin
      order_sum = {1'b0, m_ff} + {1'b0, k_ff};
      if (order_sum >= {1'b0, total_ff}) begin
         order_sum = order_sum - {1'b0, total_ff};
      end
      if (cmd.shift) begin
         rd_addr = shift_up_ff ? IW'(sc_ff - TW'(1)) : IW'(sc_ff);
      end else if (kind_ff == KIND_ALLOC && fit_ff == FIT_NEXT) begin
         rd_addr = IW'(order_sum);
      end else begin
         rd_addr = IW'(k_ff);
      end
   end

   // write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      if (cmd.init) begin
         wr_en   = 1'b1;
         wr_data = {OW'(span_c - FH_C), OW'(0)};
      end else if (cmd.shift && rd_vld_ff) begin
         wr_en   = 1'b1;
         wr_addr = shift_up_ff ? (rd_idx_ff + IW'(1)) : (rd_idx_ff - IW'(1));
         wr_data = rd_ff;
      end else if (cmd.finish && fin_we_ff) begin
         wr_en   = 1'b1;
         wr_addr = fin_addr_ff;
         wr_data = fin_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff     <= mem[rd_addr];
         rd_idx_ff <= rd_addr;
      end
   end

   assign e_s = CW'(rd_ff[OW-1:0]);
   assign e_l = CW'(rd_ff[EW-1:OW]);

   always_comb begin
      take = (e_l + FH_C >= need_ff) &&
             (!pick_found_ff ||
              (fit_ff == FIT_BEST && e_l < pick_l_ff) ||
              (fit_ff == FIT_WORST && e_l > pick_l_ff));
   end

   // outcome of one item
   always_comb begin
      logic [TW-1:0] p_eff, r1, q, t_less;
      logic          mrg_l, mrg_r;
      logic [CW-1:0] new_end;
      res_status_in   = STATUS_OK;
      res_off_in      = '0;
      res_gr_in       = '0;
      new_total_in    = total_ff;
      new_rover_in    = rover_ff;
      new_rvalid_in   = rvalid_ff;
      fin_we_in       = 1'b0;
      fin_addr_in     = '0;
      fin_data_in     = '0;
      shift_active_in = 1'b0;
      shift_up_in     = 1'b0;
      sc_in           = '0;
      sc_end_in       = '0;
      p_eff   = pfound_ff ? p_ff : total_ff;
      t_less  = total_ff - TW'(1);
      new_end = ns_ff + nl_ff + FH_C;
      mrg_l   = (p_eff != '0) && (ns_ff == prev_s_ff + prev_l_ff + FH_C);
      mrg_r   = pfound_ff && (next_s_ff == new_end);
      r1      = '0;
      q       = '0;
      if (kind_ff == KIND_ALLOC) begin
         if (!pick_found_ff) begin
            res_status_in = STATUS_NO_FIT;
         end else begin
            res_off_in = FIELD_W'(pick_s_ff + UH_C);
            if (pick_l_ff >= need_ff) begin
               // split: head goes out, remainder stays in place
               res_gr_in     = req_ff;
               fin_we_in     = 1'b1;
               fin_addr_in   = pick_idx_ff;
               fin_data_in   = {OW'(pick_l_ff - need_ff), OW'(pick_s_ff + need_ff)};
               new_rover_in  = TW'(pick_idx_ff);
               new_rvalid_in = 1'b1;
            end else begin
               // whole extent taken: close the gap
               res_gr_in       = FIELD_W'(pick_l_ff + FH_C - UH_C);
               shift_active_in = 1'b1;
               sc_in           = TW'(pick_idx_ff) + TW'(1);
               sc_end_in       = total_ff;
               new_total_in    = t_less;
               if (TW'(pick_idx_ff) < t_less) begin
                  new_rover_in = TW'(pick_idx_ff);
               end else begin
                  new_rover_in  = '0;
                  new_rvalid_in = (t_less != '0);
               end
            end
         end
      end else if (total_ff == SLOTS_C) begin
         res_status_in = STATUS_TABLE_FULL;
      end else if (!boff_low_ff && (new_end <= span_c)) begin
         r1 = rvalid_ff ? ((rover_ff >= p_eff) ? rover_ff + TW'(1) : rover_ff) : p_eff;
         q  = p_eff;
         if (mrg_l) begin
            if (r1 > p_eff) begin
               r1 = r1 - TW'(1);
            end
            q = p_eff - TW'(1);
         end
         if (mrg_r) begin
            if (r1 == q + TW'(1)) begin
               r1 = q;
            end else if (r1 > q + TW'(1)) begin
               r1 = r1 - TW'(1);
            end
         end
         new_rover_in  = r1;
         new_rvalid_in = 1'b1;
         fin_we_in     = 1'b1;
         if (mrg_l) begin
            fin_addr_in = IW'(p_eff - TW'(1));
            fin_data_in = {OW'(prev_l_ff + FH_C + nl_ff + (mrg_r ? FH_C + next_l_ff : '0)),
                           OW'(prev_s_ff)};
            if (mrg_r) begin
               shift_active_in = 1'b1;
               sc_in           = p_eff + TW'(1);
               sc_end_in       = total_ff;
               new_total_in    = t_less;
            end
         end else if (mrg_r) begin
            fin_addr_in = IW'(p_eff);
            fin_data_in = {OW'(nl_ff + FH_C + next_l_ff), OW'(ns_ff)};
         end else begin
            // plain insert: open a slot at p
            fin_addr_in     = IW'(p_eff);
            fin_data_in     = {OW'(nl_ff), OW'(ns_ff)};
            shift_active_in = 1'b1;
            shift_up_in     = 1'b1;
            sc_in           = total_ff;
            sc_end_in       = p_eff;
            new_total_in    = total_ff + TW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff          <= FIT_FIRST;
         heap_ff         <= HEAP_BYTES_RESET;
         init_req_ff     <= 1'b0;
         total_ff        <= TW'(1);
         rover_ff        <= '0;
         rvalid_ff       <= 1'b1;
         rd_vld_ff       <= 1'b0;
         k_ff            <= '0;
         pick_found_ff   <= 1'b0;
         pfound_ff       <= 1'b0;
         shift_active_ff <= 1'b0;
         out_vld_ff      <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         if (cmd.init) begin
            init_req_ff <= 1'b0;
            total_ff    <= TW'(1);
            rover_ff    <= '0;
            rvalid_ff   <= 1'b1;
         end
         if (csr_we) begin
            if (csr_index == CSR_FIT_MODE) begin
               fit_ff <= csr_wdata[FIT_W-1:0];
            end else begin
               heap_ff     <= csr_wdata;
               init_req_ff <= 1'b1;
            end
         end
         if (cmd.load) begin
            k_ff          <= '0;
            pick_found_ff <= 1'b0;
            pfound_ff     <= 1'b0;
         end
         if (scan_issue) begin
            k_ff <= k_ff + TW'(1);
         end
         if (cmd.scan && rd_vld_ff) begin
            if (kind_ff == KIND_ALLOC) begin
               if (take) begin
                  pick_found_ff <= 1'b1;
               end
            end else if (!pfound_ff && e_s >= ns_ff) begin
               pfound_ff <= 1'b1;
            end
         end
         if (cmd.decide) begin
            shift_active_ff <= shift_active_in;
         end
         if (cmd.finish) begin
            total_ff   <= new_total_ff;
            rover_ff   <= new_rover_ff;
            rvalid_ff  <= new_rvalid_ff;
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= in_kind;
         req_ff      <= in_request_bytes;
         need_ff     <= need_c;
         nl_ff       <= nl_c;
         ns_ff       <= CW'(in_block_offset) - UH_C;
         boff_low_ff <= (CW'(in_block_offset) < UH_C);
         m_ff        <= (rover_ff < total_ff) ? rover_ff : '0;
         scan_len_ff <= (in_kind == KIND_ALLOC && fit_ff == FIT_NEXT && !rvalid_ff) ?
                        '0 : total_ff;
      end
      if (cmd.scan && rd_vld_ff) begin
         if (kind_ff == KIND_ALLOC) begin
            if (take) begin
               pick_idx_ff <= rd_idx_ff;
               pick_s_ff   <= e_s;
               pick_l_ff   <= e_l;
            end
         end else if (!pfound_ff) begin
            if (e_s >= ns_ff) begin
               p_ff      <= TW'(rd_idx_ff);
               next_s_ff <= e_s;
               next_l_ff <= e_l;
            end else begin
               prev_s_ff <= e_s;
               prev_l_ff <= e_l;
            end
         end
      end
      if (cmd.decide) begin
         res_status_ff <= res_status_in;
         res_off_ff    <= res_off_in;
         res_gr_ff     <= res_gr_in;
         new_total_ff  <= new_total_in;
         new_rover_ff  <= new_rover_in;
         new_rvalid_ff <= new_rvalid_in;
         fin_we_ff     <= fin_we_in;
         fin_addr_ff   <= fin_addr_in;
         fin_data_ff   <= fin_data_in;
         shift_up_ff   <= shift_up_in;
         sc_ff         <= sc_in;
         sc_end_ff     <= sc_end_in;
      end else if (shift_issue) begin
         sc_ff <= shift_up_ff ? sc_ff - TW'(1) : sc_ff + TW'(1);
      end
      if (cmd.finish) begin
         out_status_ff <= res_status_ff;
         out_off_ff    <= res_off_ff;
         out_gr_ff     <= res_gr_ff;
         out_count_ff  <= COUNT_W'(new_total_ff);
      end
   end

   assign status.init_req   = init_req_ff;
   assign status.scan_done  = (k_ff == scan_len_ff) && !rd_vld_ff;
   assign status.shift_done = (!shift_active_ff || sc_ff == sc_end_ff) && !rd_vld_ff;
   assign status.out_busy   = out_vld_ff && !rsp_tready;

   assign out_valid   = out_vld_ff;
   assign out_status  = out_status_ff;
   assign out_offset  = out_off_ff;
   assign out_granted = out_gr_ff;
   assign out_count   = out_count_ff;
endmodule
`default_nettype wire

/* src/free_extent_allocator_unit.sv */
// top level of the free extent allocator: stream ports, controller and datapath
//
//   channel  direction  handshake              beat contents
//   req_     in         req_tvalid/req_tready  alloc or free of one block
//   rsp_     out        rsp_tvalid/rsp_tready  status, offset, size, extent count
//   csr_     in         csr_we (no wait)       fit_mode (0), heap_bytes (1)
//
// after the accept, the extent memory (one read and one write port) is scanned one slot a
// cycle over the free extents held, then shifted one slot a cycle when an extent is removed
// or inserted, with a decide step before the shift and a commit step after it; the result is
// registered at the commit, and the next beat is taken in the idle state after the commit
// synchronous reset; the init state writes the first extent after reset and after
// every heap_bytes write, req_tready is low during it
// a finished result sits in the output register, the next request is taken meanwhile;
// the commit of that next request waits while the output register is still unread
`default_nettype none
`include "free_extent_allocator_unit_macros.svh"
module free_extent_allocator_unit #(
   parameter int EXTENT_SLOTS = fea_pkg::DEF_EXTENT_SLOTS,
   parameter int OFFSET_BITS  = fea_pkg::DEF_OFFSET_BITS,
   parameter int FREE_HEADER  = fea_pkg::DEF_FREE_HEADER,
   parameter int USED_HEADER  = fea_pkg::DEF_USED_HEADER
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // request_bytes, block_offset, block_bytes
   input  wire         req_tuser,   // kind
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // result_offset, granted_bytes, free_extents, zero pad
   output logic [1:0]  rsp_tuser,   // status
   // configuration writes
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [15:0] csr_wdata
);
   import fea_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   logic [FIELD_W-1:0] rsp_offset, rsp_granted;
   logic [COUNT_W-1:0] rsp_count;

   // sequencer: scan, decide, shift, commit
   fea_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   // extent table and arithmetic
   fea_datapath #(
      .EXTENT_SLOTS (EXTENT_SLOTS),
      .OFFSET_BITS  (OFFSET_BITS),
      .FREE_HEADER  (FREE_HEADER),
      .USED_HEADER  (USED_HEADER)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .in_kind          (req_tuser),
      .in_request_bytes (req_tdata[15:0]),
      .in_block_offset  (req_tdata[31:16]),
      .in_block_bytes   (req_tdata[47:32]),
      .rsp_tready       (rsp_tready),
      .status           (dp_status),
      .out_valid        (rsp_tvalid),
      .out_status       (rsp_tuser),
      .out_offset       (rsp_offset),
      .out_granted      (rsp_granted),
      .out_count        (rsp_count)
   );

   // pack response beat
   assign rsp_tdata = {3'b000, rsp_count, rsp_granted, rsp_offset};

   // only one request in flight
   `FEA_ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   // the extent count never exceeds the table
   `FEA_ASSERT_IMPLY(a_count_bound, clock, reset, rsp_tvalid, rsp_tdata[36:32] <= EXTENT_SLOTS)
   // a failed beat carries no offset or size
   `FEA_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && rsp_tuser != STATUS_OK, rsp_tdata[31:0] == 32'd0)
endmodule
`default_nettype wire
